### rtl/timed_key_tap_queue_core_assert.svh
// Assertion macros shared by the checker of the timed key tap queue.
`ifndef TIMED_KEY_TAP_QUEUE_CORE_ASSERT_SVH
`define TIMED_KEY_TAP_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define TKTQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tktq check failed");

// Next-cycle implication, switched off while reset is high.
`define TKTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tktq check failed");

// Next-cycle implication that also holds across reset.
`define TKTQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tktq check failed");

`endif

### rtl/tktq_pkg.sv
// Types and constants of the timed key tap queue.
package tktq_pkg;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic ACTION_PRESS   = 1'b0;
   localparam logic ACTION_RELEASE = 1'b1;

   localparam int CMD_FIFO_DEPTH = 2;
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_TAP_NOW,
      KIND_STORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   code;
      logic [7:0]   mods;
      logic [15:0]  hold;
      logic         press;
   } tap_cmd_type;

   typedef struct packed {
      logic [7:0]  code;
      logic [7:0]  mods;
      logic [15:0] hold;
      logic        press;
   } tap_entry_type;

   typedef struct packed {
      logic       action;
      logic [7:0] code;
      logic [7:0] mods;
      logic       last;
   } tap_event_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_EXEC,
      BACK_EMIT2
   } back_state_type;

endpackage

### rtl/timed_key_tap_queue_core.sv
// Timed key tap queue: input items in, key press and release events out.
//
// Both sides look like queues. An item is taken when push is high and full is
// low; an event is taken when pop is high and empty is low, and the oldest
// event is shown on the rsp_ ports while empty is low.
// A front end sorts items (tick, immediate tap, stored tap, dropped code zero)
// into a two-entry command queue. The back end runs one command at a time:
// it reads the head slot of the tap ring as it takes the command in BACK_IDLE,
// acts on it in BACK_EXEC, and pushes the second event from BACK_EMIT2 when the
// command yields two events. These steps are set by the single read port of the
// ring memory. The earliest event of an item passes the command queue, BACK_IDLE
// and BACK_EXEC before it is pushed into the result queue and can be taken.
// Events go to a four-entry result queue. The back end starts a command only
// when two result slots are free, so a stalled receiver fills that queue,
// then the command queue, and then full goes high.
// Reset clears all queues, the ring's slot marks, the head and tail indexes
// and the ms count together; no clearing pass is needed.
module timed_key_tap_queue_core
   import tktq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_key_code,
   input  logic [7:0]  req_mod_bits,
   input  logic [15:0] req_hold_ms,
   input  logic        req_press_now,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_action,
   output logic [7:0]  rsp_out_code,
   output logic [7:0]  rsp_out_mods,
   output logic        rsp_last
);

   tap_cmd_type          cmdq_in_data, cmdq_out_data;
   logic                 cmdq_push, cmdq_pop, cmdq_full, cmdq_empty;
   tap_event_type        ev_data, rsp_data;
   logic                 ev_push;
   logic [RSP_CNT_W-1:0] rsp_count;
   logic                 rsp_room2;

   assign rsp_room2 = (rsp_count <= RSP_CNT_W'(RSP_FIFO_DEPTH - 2));

   tktq_front u_front (
      .push          (push),
      .full          (full),
      .req_cmd       (req_cmd),
      .req_key_code  (req_key_code),
      .req_mod_bits  (req_mod_bits),
      .req_hold_ms   (req_hold_ms),
      .req_press_now (req_press_now),
      .cmdq_full     (cmdq_full),
      .cmdq_push     (cmdq_push),
      .cmdq_data     (cmdq_in_data)
   );

   tktq_fifo #(
      .WIDTH ($bits(tap_cmd_type)),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmdq_push),
      .push_data (cmdq_in_data),
      .pop       (cmdq_pop),
      .pop_data  (cmdq_out_data),
      .full      (cmdq_full),
      .empty     (cmdq_empty),
      .count     ()
   );

   tktq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmdq_empty (cmdq_empty),
      .cmdq_data  (cmdq_out_data),
      .cmdq_pop   (cmdq_pop),
      .rsp_room2  (rsp_room2),
      .ev_push    (ev_push),
      .ev_data    (ev_data)
   );

   tktq_fifo #(
      .WIDTH ($bits(tap_event_type)),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_data),
      .pop       (pop),
      .pop_data  (rsp_data),
      .full      (),
      .empty     (empty),
      .count     (rsp_count)
   );

   assign rsp_action   = rsp_data.action;
   assign rsp_out_code = rsp_data.code;
   assign rsp_out_mods = rsp_data.mods;
   assign rsp_last     = rsp_data.last;

endmodule

### rtl/tktq_fifo.sv
// Small register FIFO used between the front, the back and the result port.
module tktq_fifo
   import tktq_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         full,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/tktq_front.sv
// Front end: accepts input items and sorts them into commands for the back end.
module tktq_front
   import tktq_pkg::*;
(
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_key_code,
   input  logic [7:0]  req_mod_bits,
   input  logic [15:0] req_hold_ms,
   input  logic        req_press_now,
   input  logic        cmdq_full,
   output logic        cmdq_push,
   output tap_cmd_type cmdq_data
);

   logic accept;
   logic drop;

   assign full   = cmdq_full;
   assign accept = push && !cmdq_full;
   // An enqueue of key code zero is taken and then forgotten.
   assign drop   = (req_cmd == CMD_ENQUEUE) && (req_key_code == 8'd0);

   always_comb begin
      cmdq_data.code  = req_key_code;
      cmdq_data.mods  = req_mod_bits;
      cmdq_data.hold  = req_hold_ms;
      cmdq_data.press = req_press_now;
      if (req_cmd == CMD_TICK) begin
         cmdq_data.kind = KIND_TICK;
      end else if (req_hold_ms == 16'd0) begin
         cmdq_data.kind = KIND_TAP_NOW;
      end else begin
         cmdq_data.kind = KIND_STORE;
      end
      cmdq_push = accept && !drop;
   end

endmodule

### rtl/tktq_back.sv
// Back end: owns the tap ring and the ms timer and turns commands into events.
module tktq_back
   import tktq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmdq_empty,
   input  tap_cmd_type   cmdq_data,
   output logic          cmdq_pop,
   input  logic          rsp_room2,
   output logic          ev_push,
   output tap_event_type ev_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   tap_entry_type          mem [QUEUE_DEPTH];
   tap_entry_type          rd_entry_ff;
   logic [QUEUE_DEPTH-1:0] valid_ff;
   back_state_type         state_ff, state_in;
   tap_cmd_type            cmd_ff, cmd_in;
   tap_event_type          second_ff, second_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic                   active_ff, active_in;
   logic [15:0]            elapsed_ff, elapsed_in;
   logic [15:0]            elapsed_inc;
   logic                   start;
   logic                   emit_two;
   logic                   clr_head, set_tail, mem_we;
   logic                   head_valid, tail_busy;
   tap_entry_type          wr_entry;

   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      slot_next = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   assign start       = (state_ff == BACK_IDLE) && !cmdq_empty && rsp_room2;
   assign head_valid  = valid_ff[head_ff];
   assign tail_busy   = valid_ff[tail_ff];
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign wr_entry    = '{code: cmd_ff.code, mods: cmd_ff.mods,
                          hold: cmd_ff.hold, press: cmd_ff.press};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE:  if (start) state_in = BACK_EXEC;
         BACK_EXEC:  state_in = emit_two ? BACK_EMIT2 : BACK_IDLE;
         BACK_EMIT2: state_in = BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cmdq_pop   = 1'b0;
      cmd_in     = cmd_ff;
      ev_push    = 1'b0;
      ev_data    = '0;
      emit_two   = 1'b0;
      second_in  = second_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      active_in  = active_ff;
      elapsed_in = elapsed_ff;
      clr_head   = 1'b0;
      set_tail   = 1'b0;
      mem_we     = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (start) begin
               cmdq_pop = 1'b1;
               cmd_in   = cmdq_data;
            end
         end
         BACK_EXEC: begin
            case (cmd_ff.kind)
               KIND_TICK: begin
                  if (head_valid && !active_ff) begin
                     active_in  = 1'b1;
                     elapsed_in = 16'd0;
                     if (rd_entry_ff.press) begin
                        ev_push = 1'b1;
                        ev_data = '{action: ACTION_PRESS, code: rd_entry_ff.code,
                                    mods: rd_entry_ff.mods, last: 1'b1};
                     end
                  end else if (head_valid) begin
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc >= rd_entry_ff.hold) begin
                        ev_push    = 1'b1;
                        ev_data    = '{action: ACTION_RELEASE, code: rd_entry_ff.code,
                                       mods: rd_entry_ff.mods, last: 1'b1};
                        clr_head   = 1'b1;
                        active_in  = 1'b0;
                        elapsed_in = 16'd0;
                        head_in    = slot_next(head_ff);
                     end
                  end
               end
               KIND_TAP_NOW: begin
                  ev_push   = 1'b1;
                  ev_data   = '{action: ACTION_PRESS, code: cmd_ff.code,
                                mods: cmd_ff.mods, last: 1'b0};
                  emit_two  = 1'b1;
                  second_in = '{action: ACTION_RELEASE, code: cmd_ff.code,
                                mods: cmd_ff.mods, last: 1'b1};
               end
               KIND_STORE: begin
                  // A busy tail slot means the ring is full: finish the head tap now.
                  if (tail_busy && head_valid) begin
                     ev_push    = 1'b1;
                     clr_head   = 1'b1;
                     active_in  = 1'b0;
                     elapsed_in = 16'd0;
                     head_in    = slot_next(head_ff);
                     if (!active_ff && rd_entry_ff.press) begin
                        ev_data   = '{action: ACTION_PRESS, code: rd_entry_ff.code,
                                      mods: rd_entry_ff.mods, last: 1'b0};
                        emit_two  = 1'b1;
                        second_in = '{action: ACTION_RELEASE, code: rd_entry_ff.code,
                                      mods: rd_entry_ff.mods, last: 1'b1};
                     end else begin
                        ev_data = '{action: ACTION_RELEASE, code: rd_entry_ff.code,
                                    mods: rd_entry_ff.mods, last: 1'b1};
                     end
                  end
                  mem_we   = 1'b1;
                  set_tail = 1'b1;
                  tail_in  = slot_next(tail_ff);
               end
               default: begin
               end
            endcase
         end
         BACK_EMIT2: begin
            ev_push = 1'b1;
            ev_data = second_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         head_ff    <= '0;
         tail_ff    <= '0;
         active_ff  <= 1'b0;
         elapsed_ff <= 16'd0;
         valid_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         active_ff  <= active_in;
         elapsed_ff <= elapsed_in;
         // When head and tail meet, the new tap's mark must win.
         if (clr_head) valid_ff[head_ff] <= 1'b0;
         if (set_tail) valid_ff[tail_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      second_ff   <= second_in;
      rd_entry_ff <= mem[head_ff];
      if (mem_we) begin
         mem[tail_ff] <= wr_entry;
      end
   end

endmodule

### rtl/tktq_checker.sv
// Port-level checks of the timed key tap queue, bound to the top level.
`include "timed_key_tap_queue_core_assert.svh"

module tktq_checker
   import tktq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        push,
   input logic        full,
   input logic        req_cmd,
   input logic [7:0]  req_key_code,
   input logic [7:0]  req_mod_bits,
   input logic [15:0] req_hold_ms,
   input logic        req_press_now,
   input logic        empty,
   input logic        pop,
   input logic        rsp_action,
   input logic [7:0]  rsp_out_code,
   input logic [7:0]  rsp_out_mods,
   input logic        rsp_last
);

   // Reset leaves both queues empty.
   `TKTQ_ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, empty && !full)

   // A release is always the final event of its item.
   `TKTQ_ASSERT_IMPL(a_release_last, clock, reset,
      !empty && rsp_action == ACTION_RELEASE, rsp_last)

   // A press that is not final is followed at once by the release of the same key.
   `TKTQ_ASSERT_NEXT(a_press_pair, clock, reset,
      pop && !empty && rsp_action == ACTION_PRESS && !rsp_last,
      !empty && rsp_action == ACTION_RELEASE && rsp_out_code == $past(rsp_out_code)
      && rsp_out_mods == $past(rsp_out_mods))

   // A waiting event holds still until it is taken.
   `TKTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_action) && $stable(rsp_out_code)
      && $stable(rsp_out_mods) && $stable(rsp_last))

endmodule

bind timed_key_tap_queue_core tktq_checker u_checker (.*);
